### rtl/core/skt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and codes of the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

	localparam int KeyW     = 32;
	localparam int ValW     = 32;
	localparam int EntryW   = KeyW + ValW;
	localparam int AddrMaxW = 10;

	localparam logic FUNC_SEARCH = 1'b0;
	localparam logic FUNC_INSERT = 1'b1;

	typedef enum logic [2:0] {
		ST_FOUND     = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_INSERTED  = 3'd2,
		ST_DUPLICATE = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef struct packed {
		logic                ren;
		logic [AddrMaxW-1:0] raddr;
		logic                wen;
		logic [AddrMaxW-1:0] waddr;
		logic [EntryW-1:0]   wdata;
	} mem_req_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] found_value;
		logic signed [31:0] prev_key;
		logic               prev_is_head;
	} result_t;

endpackage
`default_nettype wire

### rtl/core/skt_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skt_req_if
// Request channel: operation, key and value.
// ----------------------------------------------------------------------------
interface skt_req_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic signed [31:0] key;
	logic signed [31:0] value;

	modport source (output valid, func, key, value, input ready);
	modport sink   (input valid, func, key, value, output ready);
endinterface
`default_nettype wire

### rtl/core/skt_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skt_rsp_if
// Response channel: status, found value and predecessor key.
// ----------------------------------------------------------------------------
interface skt_rsp_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic signed [31:0] found_value;
	logic signed [31:0] prev_key;
	logic               prev_is_head;

	modport source (output valid, status, found_value, prev_key, prev_is_head, input ready);
	modport sink   (input valid, status, found_value, prev_key, prev_is_head, output ready);
endinterface
`default_nettype wire

### rtl/core/skt_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skt_mem
// Entry store: one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module skt_mem
	import skt_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire logic              clk,
	input  var  mem_req_t          mreq,
	output      logic [EntryW-1:0] rdata
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [EntryW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (mreq.wen) begin
			mem_q[mreq.waddr[AW-1:0]] <= mreq.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mreq.ren) begin
			rdata <= mem_q[mreq.raddr[AW-1:0]];
		end
	end
endmodule
`default_nettype wire

### rtl/core/skt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skt_ctrl
// Scan, shift and place sequencer around the entry store.
// ----------------------------------------------------------------------------
module skt_ctrl
	import skt_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic               in_func,
	input  wire logic signed [31:0] in_key,
	input  wire logic signed [31:0] in_value,
	output      mem_req_t           mreq,
	input  wire logic [EntryW-1:0]  rdata,
	output      logic               done_valid,
	input  wire logic               done_ready,
	output      result_t            done
);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_SHIFT = 4'b0100,
		S_RESP  = 4'b1000
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      pos_q;
	logic [CW-1:0]      sh_q;
	logic [CW-1:0]      wdst_q;
	logic               rpend_q;
	logic               wpend_q;
	logic               func_q;
	logic signed [31:0] key_q;
	logic signed [31:0] val_q;
	logic signed [31:0] prev_q;
	logic signed [31:0] fval_q;
	status_t            status_q;

	logic signed [31:0] rd_key;
	logic signed [31:0] rd_val;
	logic [CW-1:0]      pos_inc;
	logic               full;

	assign rd_key  = rdata[EntryW-1:ValW];
	assign rd_val  = rdata[ValW-1:0];
	assign pos_inc = pos_q + CW'(1);
	assign full    = (cnt_q == CW'(DEPTH));

	assign in_ready   = (state_q == S_IDLE);
	assign done_valid = (state_q == S_RESP);

	assign done.status       = status_q;
	assign done.found_value  = fval_q;
	assign done.prev_key     = prev_q;
	assign done.prev_is_head = (pos_q == '0);

	always_comb begin
		mreq = '0;
		case (state_q)
			S_SCAN: begin
				if (!rpend_q) begin
					if (pos_q < cnt_q) begin
						mreq.ren   = 1'b1;
						mreq.raddr = AddrMaxW'(pos_q);
					end
				end else if (rd_key < key_q && pos_inc < cnt_q) begin
					mreq.ren   = 1'b1;
					mreq.raddr = AddrMaxW'(pos_inc);
				end
			end
			S_SHIFT: begin
				if (wpend_q) begin
					mreq.wen   = 1'b1;
					mreq.waddr = AddrMaxW'(wdst_q);
					mreq.wdata = rdata;
				end else if (sh_q == pos_q) begin
					mreq.wen   = 1'b1;
					mreq.waddr = AddrMaxW'(pos_q);
					mreq.wdata = {key_q, val_q};
				end
				if (sh_q > pos_q) begin
					mreq.ren   = 1'b1;
					mreq.raddr = AddrMaxW'(sh_q - CW'(1));
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			rpend_q <= 1'b0;
			wpend_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SCAN;
						rpend_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (!rpend_q) begin
						if (pos_q < cnt_q) begin
							rpend_q <= 1'b1;
						end else if (func_q == FUNC_INSERT && !full) begin
							state_q <= S_SHIFT;
						end else begin
							state_q <= S_RESP;
						end
					end else if (rd_key < key_q) begin
						rpend_q <= (pos_inc < cnt_q);
					end else begin
						rpend_q <= 1'b0;
						if (func_q == FUNC_INSERT && rd_key != key_q && !full) begin
							state_q <= S_SHIFT;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_SHIFT: begin
					if (sh_q > pos_q) begin
						wpend_q <= 1'b1;
					end else if (wpend_q) begin
						wpend_q <= 1'b0;
					end else begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (done_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q <= in_func;
				key_q  <= in_key;
				val_q  <= in_value;
				pos_q  <= '0;
				prev_q <= '0;
				fval_q <= '0;
			end
			S_SCAN: begin
				sh_q <= cnt_q;
				if (!rpend_q) begin
					if (!(pos_q < cnt_q)) begin
						if (func_q == FUNC_SEARCH) begin
							status_q <= ST_NOT_FOUND;
						end else if (full) begin
							status_q <= ST_FULL;
						end else begin
							status_q <= ST_INSERTED;
						end
					end
				end else if (rd_key < key_q) begin
					prev_q <= rd_key;
					pos_q  <= pos_inc;
				end else if (func_q == FUNC_SEARCH) begin
					if (rd_key == key_q) begin
						status_q <= ST_FOUND;
						fval_q   <= rd_val;
					end else begin
						status_q <= ST_NOT_FOUND;
					end
				end else if (rd_key == key_q) begin
					status_q <= ST_DUPLICATE;
				end else if (full) begin
					status_q <= ST_FULL;
				end else begin
					status_q <= ST_INSERTED;
				end
			end
			S_SHIFT: begin
				if (sh_q > pos_q) begin
					wdst_q <= sh_q;
					sh_q   <= sh_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

### rtl/core/sorted_key_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_table
// Key/value table kept in ascending signed key order; search and insert.
//
//   channel  dir  payload                                     accepted when
//   req      in   func, key, value                            valid && ready
//   rsp      out  status, found_value, prev_key, prev_is_head  valid && ready
//
// One item at a time. A search reads the entries in ascending order until it
// reaches the search position; an insert then moves each entry above that
// position up by one and writes the new entry, each move going through the
// single read port of the entry store. Reset empties the table; stored entries
// need no clearing. A held response does not block the next request, which
// stalls only if its own response cannot leave.
// ----------------------------------------------------------------------------
module sorted_key_table
	import skt_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	skt_req_if.sink   req,
	skt_rsp_if.source rsp
);
	mem_req_t          mreq;
	logic [EntryW-1:0] rdata;
	logic              done_valid;
	logic              done_ready;
	result_t           done;
	logic              out_valid_q;
	result_t           out_q;

	skt_mem #(.DEPTH(DEPTH)) u_mem (
		.clk   (clk),
		.mreq  (mreq),
		.rdata (rdata)
	);

	skt_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_ready   (req.ready),
		.in_func    (req.func),
		.in_key     (req.key),
		.in_value   (req.value),
		.mreq       (mreq),
		.rdata      (rdata),
		.done_valid (done_valid),
		.done_ready (done_ready),
		.done       (done)
	);

	assign done_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_ready) begin
			out_valid_q <= done_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (done_valid && done_ready) begin
			out_q <= done;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_q.status;
	assign rsp.found_value  = out_q.found_value;
	assign rsp.prev_key     = out_q.prev_key;
	assign rsp.prev_is_head = out_q.prev_is_head;
endmodule
`default_nettype wire
